// ===== hdl/multi_waveform_oscillator_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the multi-waveform oscillator
// Shorthand for clocked concurrent checks, with and without reset gating.
// ----------------------------------------------------------------------------
`ifndef MULTI_WAVEFORM_OSCILLATOR_MACROS_SVH
`define MULTI_WAVEFORM_OSCILLATOR_MACROS_SVH

// Check held off while reset is high
`define MWO_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that also holds during reset
`define MWO_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/mwo_pkg.sv =====
// ----------------------------------------------------------------------------
// mwo_pkg
// Shared types and constants of the multi-waveform oscillator.
// ----------------------------------------------------------------------------
package mwo_pkg;

   localparam int TABLE_DEPTH_DEFAULT = 1024;
   localparam int SAMPLE_BITS_DEFAULT = 16;

   // Table entries are unsigned Q1.15 magnitudes, peak 1.0 = 32768
   localparam int ROM_WIDTH = 16;

   localparam logic [63:0] Q30_ONE     = 64'd1073741824;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   // 0.48 as 62915 / 2^17
   localparam logic [16:0] DUTY_SWING = 17'd62915;

   localparam logic [2:0]  WAVEFORM_RESET   = 3'd0;
   localparam logic [31:0] PHASE_STEP_RESET = 32'd42852281;
   localparam logic [15:0] PERIOD_RESET     = 16'd100;
   localparam logic [15:0] AMPLITUDE_RESET  = 16'd16384;
   localparam logic [31:0] LFO_STEP_RESET   = 32'd24348;

   typedef enum logic [2:0] {
      WAVE_SINE     = 3'd0,
      WAVE_SQUARE   = 3'd1,
      WAVE_SAWTOOTH = 3'd2,
      WAVE_TRIANGLE = 3'd3,
      WAVE_CIRCLE   = 3'd4,
      WAVE_PULSE    = 3'd5
   } wave_type;

   typedef enum logic [2:0] {
      CSR_WAVEFORM   = 3'd0,
      CSR_PHASE_STEP = 3'd1,
      CSR_PERIOD     = 3'd2,
      CSR_AMPLITUDE  = 3'd3,
      CSR_LFO_STEP   = 3'd4
   } csr_index_type;

endpackage

// ===== hdl/mwo_wave_rom.sv =====
// ----------------------------------------------------------------------------
// mwo_wave_rom
// Quarter-wave sine and half-circle lookup tables with registered reads.
// ----------------------------------------------------------------------------
module mwo_wave_rom #(
   parameter int TABLE_DEPTH = mwo_pkg::TABLE_DEPTH_DEFAULT,
   localparam int SINE_AW    = $clog2(TABLE_DEPTH + 1),
   localparam int CIRCLE_AW  = $clog2(TABLE_DEPTH)
) (
   input  logic                            clock,
   input  logic                            rd_en,
   input  logic [SINE_AW-1:0]              sine_addr,
   input  logic [CIRCLE_AW-1:0]            circle_addr,
   output logic [mwo_pkg::ROM_WIDTH-1:0]   sine_data,
   output logic [mwo_pkg::ROM_WIDTH-1:0]   circle_data
);

   localparam logic [63:0] DEPTH_SQ = 64'(TABLE_DEPTH) * 64'(TABLE_DEPTH);
   localparam logic [63:0] DEPTH_64 = 64'(TABLE_DEPTH);

   typedef logic [mwo_pkg::ROM_WIDTH-1:0] sine_rom_type   [TABLE_DEPTH + 1];
   typedef logic [mwo_pkg::ROM_WIDTH-1:0] circle_rom_type [TABLE_DEPTH];

   // sin(k*pi/(2*depth)) in Q15 via a Q30 Taylor series in Horner form
   function automatic logic [mwo_pkg::ROM_WIDTH-1:0] sine_entry(input int unsigned k);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      x  = (64'(k) * mwo_pkg::HALF_PI_Q30) / DEPTH_64;
      x2 = (x * x) >> 30;
      t  = mwo_pkg::Q30_ONE;
      t  = mwo_pkg::Q30_ONE - (((x2 * t) >> 30) / 64'd156);
      t  = mwo_pkg::Q30_ONE - (((x2 * t) >> 30) / 64'd110);
      t  = mwo_pkg::Q30_ONE - (((x2 * t) >> 30) / 64'd72);
      t  = mwo_pkg::Q30_ONE - (((x2 * t) >> 30) / 64'd42);
      t  = mwo_pkg::Q30_ONE - (((x2 * t) >> 30) / 64'd20);
      t  = mwo_pkg::Q30_ONE - (((x2 * t) >> 30) / 64'd6);
      return mwo_pkg::ROM_WIDTH'((((x * t) >> 30) + 64'd16384) >> 15);
   endfunction

   // integer square root, rounded to nearest
   function automatic logic [63:0] isqrt_round(input logic [63:0] v_in);
      logic [63:0] v;
      logic [63:0] r;
      logic [63:0] b;
      v = v_in;
      r = '0;
      b = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      if (v > r) begin
         r = r + 64'd1;
      end
      return r;
   endfunction

   function automatic sine_rom_type build_sine();
      sine_rom_type rom;
      for (int k = 0; k <= TABLE_DEPTH; k++) begin
         rom[k] = sine_entry(k);
      end
      return rom;
   endfunction

   function automatic circle_rom_type build_circle();
      circle_rom_type rom;
      longint         g;
      logic [63:0]    num;
      for (int k = 0; k < TABLE_DEPTH; k++) begin
         g      = 2 * longint'(k) - longint'(TABLE_DEPTH);
         num    = DEPTH_SQ - 64'(g * g);
         rom[k] = mwo_pkg::ROM_WIDTH'(isqrt_round((num << 30) / DEPTH_SQ));
      end
      return rom;
   endfunction

   localparam sine_rom_type   SINE_ROM   = build_sine();
   localparam circle_rom_type CIRCLE_ROM = build_circle();

   logic [mwo_pkg::ROM_WIDTH-1:0] sine_data_ff;
   logic [mwo_pkg::ROM_WIDTH-1:0] circle_data_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         sine_data_ff   <= SINE_ROM[sine_addr];
         circle_data_ff <= CIRCLE_ROM[circle_addr];
      end
   end

   assign sine_data   = sine_data_ff;
   assign circle_data = circle_data_ff;

endmodule

// ===== hdl/multi_waveform_oscillator.sv =====
// ----------------------------------------------------------------------------
// multi_waveform_oscillator
// Phase-accumulator tone source: sine, square, sawtooth, triangle, half-circle
// and LFO-swept pulse, scaled by a Q2.14 gain to a saturated signed sample.
// ----------------------------------------------------------------------------
//  channel   ports                          direction  content
//  req       req_valid / req_ready          in         restart flag
//  rsp       rsp_valid / rsp_ready          out        sample, period_start
//  csr       csr_we / csr_index / csr_wdata in         register write
//
//  One tick per clock unless the output stalls; rsp_valid follows the last stage.
//  Stages: phase/index update, table read (ROM port), wave select and duty
//  compare, gain multiply with round and saturate into the output register.
//  Reset clears phase, index, LFO phase and pipeline; registers take defaults.
//  A stalled output holds; upstream stages keep filling bubbles, so up to
//  four transactions are held before req_ready drops.
// ----------------------------------------------------------------------------
`include "multi_waveform_oscillator_macros.svh"

module multi_waveform_oscillator #(
   parameter int TABLE_DEPTH = mwo_pkg::TABLE_DEPTH_DEFAULT,
   parameter int SAMPLE_BITS = mwo_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_restart,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] rsp_sample,
   output logic                          rsp_period_start,
   input  logic                          csr_we,
   input  logic [2:0]                    csr_index,
   input  logic [31:0]                   csr_wdata
);

   localparam int SINE_AW   = $clog2(TABLE_DEPTH + 1);
   localparam int CIRCLE_AW = $clog2(TABLE_DEPTH);
   localparam int PROD_W    = 31 + SINE_AW;
   localparam int SHIFT     = 30 - SAMPLE_BITS;
   localparam logic signed [34:0] ROUND_HALF = 35'sd1 <<< (SHIFT - 1);
   localparam logic signed [34:0] SAT_HI     = (35'sd1 <<< (SAMPLE_BITS - 1)) - 35'sd1;
   localparam logic signed [34:0] SAT_LO     = -SAT_HI - 35'sd1;

   // configuration
   logic [2:0]  waveform_ff;
   logic [31:0] phase_step_ff;
   logic [15:0] period_ff;
   logic [15:0] amplitude_ff;
   logic [31:0] lfo_step_ff;

   // oscillator state
   logic [31:0] phase_ff, phase_in;
   logic [15:0] index_ff, index_in;
   logic [31:0] lfo_ff, lfo_in;

   // pipeline
   logic                 v1_ff, v2_ff, v3_ff, vout_ff;
   logic                 en1, en2, en3, en_out, accept;
   logic [31:0]          u1_ff, u2_ff;
   logic [2:0]           wf1_ff, wf2_ff;
   logic [1:0]           quad1_ff, quad2_ff;
   logic [CIRCLE_AW-1:0] k1_ff;
   logic                 ps1_ff, ps2_ff, ps3_ff;
   logic signed [16:0]   wave3_ff, wave_in;
   logic signed [SAMPLE_BITS-1:0] sample_ff, sample_in;
   logic                 ps_out_ff;

   logic [31:0] cur_phase, cur_lfo, sel_phase;
   logic [15:0] cur_index;
   logic [16:0] index_inc;
   logic        is_pulse;
   logic [30:0] frac;
   logic [PROD_W-1:0] idx_prod;

   logic [SINE_AW-1:0]             sine_addr;
   logic [mwo_pkg::ROM_WIDTH-1:0]  sine_data, circle_data;

   logic signed [16:0] sine_s, circle_s, saw_s, tri_hi, square_s, pulse_s;
   logic signed [17:0] tri_lo;
   logic signed [33:0] pulse_prod, gain_prod;
   logic signed [34:0] cut, u_ext, rounded, quot;

   // ---------------------------------------------------------------- handshake
   assign en_out    = !vout_ff || rsp_ready;
   assign en3       = !v3_ff || en_out;
   assign en2       = !v2_ff || en3;
   assign en1       = !v1_ff || en2;
   assign req_ready = en1;
   assign accept    = req_valid && en1;

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         waveform_ff   <= mwo_pkg::WAVEFORM_RESET;
         phase_step_ff <= mwo_pkg::PHASE_STEP_RESET;
         period_ff     <= mwo_pkg::PERIOD_RESET;
         amplitude_ff  <= mwo_pkg::AMPLITUDE_RESET;
         lfo_step_ff   <= mwo_pkg::LFO_STEP_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            mwo_pkg::CSR_WAVEFORM:   waveform_ff   <= csr_wdata[2:0];
            mwo_pkg::CSR_PHASE_STEP: phase_step_ff <= csr_wdata;
            mwo_pkg::CSR_PERIOD:     period_ff     <= csr_wdata[15:0];
            mwo_pkg::CSR_AMPLITUDE:  amplitude_ff  <= csr_wdata[15:0];
            mwo_pkg::CSR_LFO_STEP:   lfo_step_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- stage 1
   always_comb begin
      is_pulse  = (waveform_ff == mwo_pkg::WAVE_PULSE);
      cur_phase = req_restart ? 32'd0 : phase_ff;
      cur_index = req_restart ? 16'd0 : index_ff;
      cur_lfo   = (req_restart ? 32'd0 : lfo_ff) + (is_pulse ? lfo_step_ff : 32'd0);
      index_inc = {1'b0, cur_index} + 17'd1;
      lfo_in    = cur_lfo;
      if (is_pulse) begin
         phase_in = cur_phase + phase_step_ff;
         index_in = (cur_index == 16'hFFFF) ? cur_index : index_inc[15:0];
      end else if (index_inc >= {1'b0, period_ff}) begin
         // zero period length lands here too
         phase_in = 32'd0;
         index_in = 16'd0;
      end else begin
         phase_in = cur_phase + phase_step_ff;
         index_in = index_inc[15:0];
      end
   end

   // table index: sine uses the phase within its quadrant, circle the phase
   // within the half period; both as a 31-bit fraction times the depth
   assign sel_phase = is_pulse ? cur_lfo : cur_phase;
   assign frac      = (waveform_ff == mwo_pkg::WAVE_CIRCLE) ? cur_phase[30:0]
                                                            : {sel_phase[29:0], 1'b0};
   assign idx_prod  = PROD_W'(frac) * PROD_W'(TABLE_DEPTH);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         index_ff <= '0;
         lfo_ff   <= '0;
         v1_ff    <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff <= phase_in;
            index_ff <= index_in;
            lfo_ff   <= lfo_in;
         end
         if (en1) begin
            v1_ff <= req_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         u1_ff    <= cur_phase;
         wf1_ff   <= waveform_ff;
         quad1_ff <= sel_phase[31:30];
         k1_ff    <= idx_prod[31 +: CIRCLE_AW];
         ps1_ff   <= (cur_index == 16'd0);
      end
   end

   // ---------------------------------------------------------------- stage 2
   // odd quadrants read the table mirrored
   assign sine_addr = quad1_ff[0] ? (SINE_AW'(TABLE_DEPTH) - SINE_AW'(k1_ff))
                                  : SINE_AW'(k1_ff);

   mwo_wave_rom #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_rom (
      .clock       (clock),
      .rd_en       (en2),
      .sine_addr   (sine_addr),
      .circle_addr (k1_ff),
      .sine_data   (sine_data),
      .circle_data (circle_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en2) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         u2_ff    <= u1_ff;
         wf2_ff   <= wf1_ff;
         quad2_ff <= quad1_ff;
         ps2_ff   <= ps1_ff;
      end
   end

   // ---------------------------------------------------------------- stage 3
   always_comb begin
      sine_s     = quad2_ff[1] ? -$signed({1'b0, sine_data}) : $signed({1'b0, sine_data});
      circle_s   = u2_ff[31] ? -$signed({1'b0, circle_data}) : $signed({1'b0, circle_data});
      square_s   = (u2_ff > 32'h8000_0000) ? 17'sd32768 : -17'sd32768;
      saw_s      = $signed({~u2_ff[31], ~u2_ff[31], u2_ff[30:16]});
      tri_hi     = $signed({1'b0, u2_ff[30:15]}) - 17'sd32768;
      tri_lo     = 18'sd32768 - $signed({1'b0, u2_ff[31:15]});
      // duty cutoff 0.5 + 0.48 * sine of the LFO phase
      pulse_prod = sine_s * $signed(mwo_pkg::DUTY_SWING);
      cut        = $signed(35'h0_8000_0000) + $signed({pulse_prod[33], pulse_prod});
      u_ext      = $signed({3'b000, u2_ff});
      pulse_s    = (u_ext > cut) ? 17'sd32768 : -17'sd32768;
      case (wf2_ff)
         mwo_pkg::WAVE_SINE:     wave_in = sine_s;
         mwo_pkg::WAVE_SQUARE:   wave_in = square_s;
         mwo_pkg::WAVE_SAWTOOTH: wave_in = saw_s;
         mwo_pkg::WAVE_TRIANGLE: wave_in = (u2_ff > 32'h8000_0000) ? tri_hi : tri_lo[16:0];
         mwo_pkg::WAVE_CIRCLE:   wave_in = circle_s;
         mwo_pkg::WAVE_PULSE:    wave_in = pulse_s;
         default:                wave_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en3) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         wave3_ff <= wave_in;
         ps3_ff   <= ps2_ff;
      end
   end

   // ---------------------------------------------------------------- output
   always_comb begin
      gain_prod = wave3_ff * $signed({1'b0, amplitude_ff});
      rounded   = $signed({gain_prod[33], gain_prod}) + ROUND_HALF;
      quot      = rounded >>> SHIFT;
      if (quot > SAT_HI) begin
         sample_in = SAT_HI[SAMPLE_BITS-1:0];
      end else if (quot < SAT_LO) begin
         sample_in = SAT_LO[SAMPLE_BITS-1:0];
      end else begin
         sample_in = quot[SAMPLE_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vout_ff <= 1'b0;
      end else if (en_out) begin
         vout_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en_out) begin
         sample_ff <= sample_in;
         ps_out_ff <= ps3_ff;
      end
   end

   assign rsp_valid        = vout_ff;
   assign rsp_sample       = sample_ff;
   assign rsp_period_start = ps_out_ff;

   // ---------------------------------------------------------------- checks
   `MWO_ASSERT(a_restart_index, clock, reset,
      (accept && req_restart) |=> (index_ff <= 16'd1),
      "index not cleared by restart")
   `MWO_ASSERT(a_restart_start, clock, reset,
      (accept && req_restart) |=> (v1_ff && ps1_ff),
      "restart transaction lacks period start")
   `MWO_ASSERT(a_index_in_period, clock, reset,
      (accept && waveform_ff != mwo_pkg::WAVE_PULSE)
         |=> (index_ff == 16'd0 || index_ff < $past(period_ff)),
      "index ran past period length")
   `MWO_ASSERT(a_stall_holds, clock, reset,
      (vout_ff && !rsp_ready && v3_ff) |=> (vout_ff && v3_ff),
      "transaction dropped under output stall")

endmodule
